@@ rtl/core/asfm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfm_pkg
// Shared types and constants for the adaptive symbol frequency model.
// ----------------------------------------------------------------------------
package asfm_pkg;

  localparam int NUM_SYMBOLS_DEF = 256;
  localparam int BLOCK_SIZE_DEF  = 32;

  typedef logic [14:0] limit_t;

  localparam limit_t LIMIT_RESET = 15'd32000;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_DECODE = 2'd2,
    CMD_INIT   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  symbol;
    logic [10:0] increment;
    logic [15:0] target_value;
  } in_word_t;

  typedef struct packed {
    logic        rescaled;
    logic        decode_error;
    logic [7:0]  found_symbol;
    logic [15:0] cum_low;
    logic [15:0] frequency;
    logic [15:0] total;
  } out_word_t;

endpackage

@@ rtl/core/asfm_chan_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfm_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface asfm_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/asfm_blk_split.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfm_blk_split
// Splits a symbol into block index, block start and offset in the block.
// Quotient by reciprocal multiply, registered; base and offset follow it.
// ----------------------------------------------------------------------------
module asfm_blk_split #(
  parameter int NUM_SYMBOLS = 256,
  parameter int BLOCK_SIZE  = 32
) (
  input  logic                                    clk_i,
  input  logic [$clog2(NUM_SYMBOLS)-1:0]          sym_i,
  output logic [$clog2((NUM_SYMBOLS + BLOCK_SIZE - 1) / BLOCK_SIZE + 1)-1:0] blk_o,
  output logic [$clog2(NUM_SYMBOLS)-1:0]          base_o,
  output logic [((BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1)-1:0] off_o
);
  localparam int NBLK   = (NUM_SYMBOLS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int SYM_W  = $clog2(NUM_SYMBOLS);
  localparam int BLK_W  = $clog2(NBLK + 1);
  localparam int OFF_W  = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
  // exact floor for every sym < 2**SYM_W
  localparam int K      = SYM_W + $clog2(BLOCK_SIZE);
  localparam int RECIP  = ((1 << K) + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int PROD_W = SYM_W + K + 1;
  localparam int MUL_W  = SYM_W + 9;

  logic [PROD_W-1:0] prod;
  logic [BLK_W-1:0]  blk_q;
  logic [SYM_W-1:0]  sym_q;
  logic [MUL_W-1:0]  base_full;
  logic [SYM_W-1:0]  off_full;

  assign prod = PROD_W'(sym_i) * PROD_W'(RECIP);

  always_ff @(posedge clk_i) begin
    blk_q <= prod[K +: BLK_W];
    sym_q <= sym_i;
  end

  assign base_full = MUL_W'(blk_q) * MUL_W'(BLOCK_SIZE);
  assign base_o    = base_full[SYM_W-1:0];
  assign off_full  = sym_q - base_o;
  assign off_o     = OFF_W'(off_full);
  assign blk_o     = blk_q;

endmodule

@@ rtl/core/asfm_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfm_engine
// Sequencer around the frequency memory and the block-start memory.
// ----------------------------------------------------------------------------
module asfm_engine
  import asfm_pkg::*;
#(
  parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF,
  parameter int BLOCK_SIZE  = BLOCK_SIZE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  input  in_word_t  item_i,
  output logic      item_ready_o,
  input  limit_t    limit_i,
  output logic      res_valid_o,
  output out_word_t res_o,
  input  logic      res_ready_i
);
  localparam int NBLK  = (NUM_SYMBOLS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int SYM_W = $clog2(NUM_SYMBOLS);
  localparam int CNT_W = $clog2(NUM_SYMBOLS + 1);
  localparam int BLK_W = $clog2(NBLK + 1);
  localparam int SA_W  = (NBLK > 1) ? $clog2(NBLK) : 1;
  localparam int OFF_W = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

  localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(NUM_SYMBOLS - 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_SYMBOLS - 1);
  localparam logic [CNT_W-1:0] NSYM_C   = CNT_W'(NUM_SYMBOLS);
  localparam logic [OFF_W-1:0] LAST_POS = OFF_W'(BLOCK_SIZE - 1);
  localparam logic [BLK_W-1:0] NBLK_C   = BLK_W'(NBLK);
  localparam logic [15:0]      NSYM_TOT = 16'(NUM_SYMBOLS);
  localparam logic [SYM_W-1:0] BLK_STEP = SYM_W'(BLOCK_SIZE);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_UPD_RD, ST_UPD_WR, ST_FIX, ST_CHK, ST_RSC,
    ST_SUM_RD, ST_SUM_LD, ST_BS_RD, ST_BS_CHK, ST_WALK_RD, ST_WALK, ST_DONE
  } state_e;

  state_e           state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  logic [SYM_W-1:0] sym_q, sym_d, cur_q, cur_d;
  logic [10:0]      inc_q, inc_d;
  logic [15:0]      tgt_q, tgt_d;
  logic [OFF_W-1:0] rem_q, rem_d, pos_q, pos_d;
  logic [BLK_W-1:0] blk_q, blk_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wv_q, wv_d, pend_q, pend_d, dec_walk_q, dec_walk_d;
  logic             resc_q, resc_d, derr_q, derr_d;
  logic [15:0]      acc_q, acc_d, cl_q, cl_d, fr_q, fr_d, total_q, total_d;

  // frequency memory
  logic [15:0]      freq_mem [NUM_SYMBOLS];
  logic             f_we, f_re;
  logic [SYM_W-1:0] f_waddr, f_raddr;
  logic [15:0]      f_wdata, f_rdata_q;
  // block-start memory, entry k = sum of frequencies below symbol k*BLOCK_SIZE
  logic [15:0]      sum_mem [NBLK];
  logic             s_we, s_re;
  logic [SA_W-1:0]  s_waddr, s_raddr;
  logic [15:0]      s_wdata, s_rdata_q;

  logic [BLK_W-1:0] sp_blk;
  logic [SYM_W-1:0] sp_base;
  logic [OFF_W-1:0] sp_off;

  logic [SYM_W-1:0] sym_sat;
  logic [16:0]      f_plus1, walk_sum;
  logic [15:0]      half;
  logic [BLK_W-1:0] blk_m1, blk_p1;
  logic [CNT_W-1:0] cnt_m1;
  logic             dec_more, walk_stop;

  asfm_blk_split #(
    .NUM_SYMBOLS(NUM_SYMBOLS),
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_split (
    .clk_i (clk_i),
    .sym_i (sym_q),
    .blk_o (sp_blk),
    .base_o(sp_base),
    .off_o (sp_off)
  );

  assign sym_sat  = (int'(item_i.symbol) >= NUM_SYMBOLS) ? LAST_SYM
                                                          : SYM_W'(item_i.symbol);
  assign f_plus1  = {1'b0, f_rdata_q} + 17'd1;
  assign half     = f_plus1[16:1];
  assign walk_sum = {1'b0, cl_q} + {1'b0, f_rdata_q};
  assign blk_m1   = blk_q - BLK_W'(1);
  assign blk_p1   = blk_q + BLK_W'(1);
  assign cnt_m1   = cnt_q - CNT_W'(1);
  assign dec_more = (cur_q != LAST_SYM) && (walk_sum <= {1'b0, tgt_q});
  assign walk_stop = dec_walk_q ? !dec_more : (rem_q == '0);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    sym_d      = sym_q;
    cur_d      = cur_q;
    inc_d      = inc_q;
    tgt_d      = tgt_q;
    rem_d      = rem_q;
    pos_d      = pos_q;
    blk_d      = blk_q;
    cnt_d      = cnt_q;
    wv_d       = wv_q;
    pend_d     = pend_q;
    dec_walk_d = dec_walk_q;
    resc_d     = resc_q;
    derr_d     = derr_q;
    acc_d      = acc_q;
    cl_d       = cl_q;
    fr_d       = fr_q;
    total_d    = total_q;

    f_we    = 1'b0;
    f_re    = 1'b0;
    f_waddr = sym_q;
    f_raddr = cur_q;
    f_wdata = '0;
    s_we    = 1'b0;
    s_re    = 1'b0;
    s_waddr = blk_q[SA_W-1:0];
    s_raddr = blk_q[SA_W-1:0];
    s_wdata = '0;

    item_ready_o = 1'b0;
    res_valid_o  = 1'b0;

    unique case (state_q)
      // one entry per cycle: frequency to one, block start at each block head
      ST_CLEAR: begin
        f_we    = 1'b1;
        f_waddr = cnt_q[SYM_W-1:0];
        f_wdata = 16'd1;
        if (pos_q == '0) begin
          s_we    = 1'b1;
          s_wdata = 16'(cnt_q);
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (pos_q == LAST_POS) begin
          pos_d = '0;
          blk_d = blk_p1;
        end else begin
          pos_d = pos_q + OFF_W'(1);
        end
        if (cnt_q == LAST_CNT) begin
          total_d = NSYM_TOT;
          state_d = pend_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          cmd_d      = item_i.cmd;
          sym_d      = sym_sat;
          inc_d      = item_i.increment;
          tgt_d      = item_i.target_value;
          resc_d     = 1'b0;
          derr_d     = 1'b0;
          cl_d       = '0;
          fr_d       = '0;
          cur_d      = '0;
          dec_walk_d = 1'b0;
          unique case (item_i.cmd)
            CMD_INIT: begin
              cnt_d   = '0;
              pos_d   = '0;
              blk_d   = '0;
              pend_d  = 1'b1;
              state_d = ST_CLEAR;
            end
            CMD_UPDATE, CMD_QUERY: begin
              state_d = ST_DIV;
            end
            CMD_DECODE: begin
              if (item_i.target_value >= total_q) begin
                derr_d  = 1'b1;
                sym_d   = LAST_SYM;
                state_d = ST_DIV;
              end else begin
                dec_walk_d = 1'b1;
                blk_d      = BLK_W'(1);
                state_d    = (NBLK > 1) ? ST_BS_RD : ST_WALK_RD;
              end
            end
          endcase
        end
      end
      ST_DIV: begin
        state_d = (cmd_q == CMD_UPDATE) ? ST_UPD_RD : ST_SUM_RD;
      end
      ST_UPD_RD: begin
        f_re    = 1'b1;
        f_raddr = sym_q;
        blk_d   = sp_blk + BLK_W'(1);
        state_d = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        f_we    = 1'b1;
        f_waddr = sym_q;
        f_wdata = f_rdata_q + 16'(inc_q);
        total_d = total_q + 16'(inc_q);
        wv_d    = 1'b0;
        state_d = ST_FIX;
      end
      // streamed read-add-write of later block starts, each write trails its read
      ST_FIX: begin
        if (wv_q) begin
          s_we    = 1'b1;
          s_waddr = blk_m1[SA_W-1:0];
          s_wdata = s_rdata_q + 16'(inc_q);
        end
        if (blk_q < NBLK_C) begin
          s_re  = 1'b1;
          blk_d = blk_p1;
          wv_d  = 1'b1;
        end else begin
          wv_d    = 1'b0;
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (total_q > {1'b0, limit_i}) begin
          resc_d  = 1'b1;
          cnt_d   = '0;
          pos_d   = '0;
          blk_d   = '0;
          acc_d   = '0;
          state_d = ST_RSC;
        end else begin
          state_d = ST_SUM_RD;
        end
      end
      // halve with round-up and rebuild block starts in one pass
      ST_RSC: begin
        if (cnt_q < NSYM_C) begin
          f_re    = 1'b1;
          f_raddr = cnt_q[SYM_W-1:0];
        end
        if (cnt_q != '0) begin
          f_we    = 1'b1;
          f_waddr = cnt_m1[SYM_W-1:0];
          f_wdata = half;
          if (pos_q == '0) begin
            s_we    = 1'b1;
            s_wdata = acc_q;
          end
          acc_d = acc_q + half;
          if (pos_q == LAST_POS) begin
            pos_d = '0;
            blk_d = blk_p1;
          end else begin
            pos_d = pos_q + OFF_W'(1);
          end
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == NSYM_C) begin
          total_d = acc_q + half;
          state_d = ST_SUM_RD;
        end
      end
      ST_SUM_RD: begin
        s_re    = 1'b1;
        s_raddr = sp_blk[SA_W-1:0];
        cur_d   = sp_base;
        rem_d   = sp_off;
        state_d = ST_SUM_LD;
      end
      ST_SUM_LD: begin
        cl_d    = s_rdata_q;
        f_re    = 1'b1;
        state_d = ST_WALK;
      end
      ST_BS_RD: begin
        s_re    = 1'b1;
        state_d = ST_BS_CHK;
      end
      // block starts rise strictly: stop at the first one above the target
      ST_BS_CHK: begin
        if (s_rdata_q <= tgt_q) begin
          cl_d  = s_rdata_q;
          cur_d = cur_q + BLK_STEP;
          if (blk_p1 < NBLK_C) begin
            blk_d   = blk_p1;
            s_re    = 1'b1;
            s_raddr = blk_p1[SA_W-1:0];
          end else begin
            state_d = ST_WALK_RD;
          end
        end else begin
          state_d = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        f_re    = 1'b1;
        state_d = ST_WALK;
      end
      // next entry is read every cycle while the walk goes on; none is read when it stops
      ST_WALK: begin
        if (walk_stop) begin
          fr_d    = f_rdata_q;
          state_d = ST_DONE;
        end else begin
          cl_d    = walk_sum[15:0];
          cur_d   = cur_q + SYM_W'(1);
          rem_d   = rem_q - OFF_W'(1);
          f_re    = 1'b1;
          f_raddr = cur_q + SYM_W'(1);
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          pend_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cmd_q      <= CMD_QUERY;
      sym_q      <= '0;
      cur_q      <= '0;
      inc_q      <= '0;
      tgt_q      <= '0;
      rem_q      <= '0;
      pos_q      <= '0;
      blk_q      <= '0;
      cnt_q      <= '0;
      wv_q       <= 1'b0;
      pend_q     <= 1'b0;
      dec_walk_q <= 1'b0;
      resc_q     <= 1'b0;
      derr_q     <= 1'b0;
      acc_q      <= '0;
      cl_q       <= '0;
      fr_q       <= '0;
      total_q    <= NSYM_TOT;
    end else begin
      state_q    <= state_d;
      cmd_q      <= cmd_d;
      sym_q      <= sym_d;
      cur_q      <= cur_d;
      inc_q      <= inc_d;
      tgt_q      <= tgt_d;
      rem_q      <= rem_d;
      pos_q      <= pos_d;
      blk_q      <= blk_d;
      cnt_q      <= cnt_d;
      wv_q       <= wv_d;
      pend_q     <= pend_d;
      dec_walk_q <= dec_walk_d;
      resc_q     <= resc_d;
      derr_q     <= derr_d;
      acc_q      <= acc_d;
      cl_q       <= cl_d;
      fr_q       <= fr_d;
      total_q    <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      freq_mem[f_waddr] <= f_wdata;
    end
    if (f_re) begin
      f_rdata_q <= freq_mem[f_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      sum_mem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      s_rdata_q <= sum_mem[s_raddr];
    end
  end

  assign res_o.rescaled     = resc_q;
  assign res_o.decode_error = derr_q;
  assign res_o.found_symbol = 8'(cur_q);
  assign res_o.cum_low      = cl_q;
  assign res_o.frequency    = fr_q;
  assign res_o.total        = total_q;

  // total stays at least the symbol count, as every frequency stays at least one
  a_total_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q >= NSYM_TOT)
    else $error("total below symbol count");

  a_freq_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_re && f_we) |-> (f_raddr != f_waddr))
    else $error("frequency memory read and write hit one entry");

  a_sum_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_re && s_we) |-> (s_raddr != s_waddr))
    else $error("block-start memory read and write hit one entry");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && !dec_walk_q) |-> (cur_q <= sym_q))
    else $error("lookup walk ran past its symbol");

  a_derr_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && derr_q) |-> (cur_q == LAST_SYM))
    else $error("decode error not clamped to last symbol");

endmodule

@@ rtl/core/adaptive_symbol_frequency_model.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_symbol_frequency_model
// Adaptive order-0 frequency model for an arithmetic coder.
// ----------------------------------------------------------------------------
// Channels: cfg_i writes the rescale limit (always ready); in_i takes one
// command word (update, query, decode, reinitialize); out_o returns one
// result word per command. All use valid/ready, a word moves when both high.
// One command is worked at a time; in_i is ready only between commands.
// A query reads its block start and walks the entries of its block up to
// the symbol. An update adds the increment to the symbol's frequency and
// to every block start above its block, rescales (halves every frequency,
// rounding up) when the total passes the limit, then answers as a query.
// A decode scans the block starts, then walks at most BLOCK_SIZE entries;
// a target at or above the total runs as a query of the last symbol.
// Reinitialize sets every frequency to one and rebuilds the block starts.
// The walks over the frequency memory and the block-start memory take one
// entry per cycle.
// Reset: a clearing pass fills the tables; in_i stays not ready meanwhile,
// cfg_i writes are taken as ever. A stalled out_o holds its word; the next
// command is still accepted and worked, and its result waits in the engine
// until the output register frees.
module adaptive_symbol_frequency_model
  import asfm_pkg::*;
#(
  parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF,
  parameter int BLOCK_SIZE  = BLOCK_SIZE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  asfm_chan_if.sink   cfg_i,
  asfm_chan_if.sink   in_i,
  asfm_chan_if.source out_o
);
  limit_t    limit_q;
  logic      out_valid_q;
  out_word_t out_q;
  logic      res_valid, res_ready;
  out_word_t res_word;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.data;
    end
  end

  asfm_engine #(
    .NUM_SYMBOLS(NUM_SYMBOLS),
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(in_i.valid),
    .item_i      (in_i.data),
    .item_ready_o(in_i.ready),
    .limit_i     (limit_q),
    .res_valid_o (res_valid),
    .res_o       (res_word),
    .res_ready_i (res_ready)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
      out_q       <= res_word;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule
